[sv/pld_pkg.sv]
// Shared types, constants and control structs for the PalmDOC LZ77 decoder.
package pld_pkg;

  localparam int unsigned WINDOW_DEPTH = 2048;   // history depth, power of two
  localparam int unsigned WIN_AW       = $clog2(WINDOW_DEPTH);
  localparam int unsigned RECORD_MAX   = 4096;
  localparam int unsigned AFTER_W      = $clog2(RECORD_MAX);
  localparam int unsigned DIST_LIMIT   = 2048;   // record_written saturates here
  localparam int unsigned RW_W         = $clog2(DIST_LIMIT) + 1;
  localparam int unsigned CAP_W        = 24;
  localparam int unsigned CNT_W        = 4;

  localparam logic [7:0]       TOK_PAIR_LO  = 8'h80;
  localparam logic [7:0]       TOK_SPACE_LO = 8'hC0;
  localparam logic [7:0]       TOK_RAW_LO   = 8'h01;
  localparam logic [7:0]       TOK_RAW_HI   = 8'h08;
  localparam logic [7:0]       SPACE_CHAR   = 8'h20;
  localparam logic [7:0]       XOR_MASK     = 8'h80;
  localparam logic [CNT_W-1:0] LEN_BIAS     = 4'd3;
  localparam logic [CAP_W-1:0] CAP_RESET    = '1;

  typedef struct packed {
    logic [7:0]         in_byte;
    logic [AFTER_W-1:0] bytes_after;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_run;
  } out_item_t;

  // what one accepted token asks for
  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_ONE  = 2'd1,
    ACT_TWO  = 2'd2,
    ACT_COPY = 2'd3
  } act_e;

  typedef struct packed {
    logic accept;    // take the input item, update decode state
    logic emit;      // push one byte into history and output register
    logic from_mem;  // emitted byte comes from history read data
    logic rd_issue;  // read history at write_index - distance
  } dp_cmd_t;

  typedef struct packed {
    act_e act;       // decode of the waiting input item
    logic out_free;  // output register can take a byte this cycle
    logic last;      // next emitted byte is the final one of the item
  } dp_sts_t;

endpackage

[sv/palmdoc_lz77_decompressor.sv]
// Top level of the PalmDOC LZ77 decoder: one compressed byte in, decoded bytes out.
//
//   channel  dir  handshake               payload
//   in       in   in_valid_i/in_ready_o   in_item_i  (in_byte, bytes_after)
//   out      out  out_valid_o/out_ready_i out_item_o (out_byte, last_of_run)
//   cfg      in   cfg_we_i                cfg_wdata_i (output_capacity)
//
// A token that yields nothing ends when taken. Literal, raw-run and space bytes
// leave from the emit state; each back-reference byte has a read state (history
// read is registered) and then a write state, where it is written back and emitted.
// No clearing pass after reset; unwritten history is never read legally.
// A full output register stalls emission; input is taken only when idle.
module palmdoc_lz77_decompressor (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  pld_pkg::in_item_t          in_item_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output pld_pkg::out_item_t         out_item_o,
  input  logic                       cfg_we_i,
  input  logic [pld_pkg::CAP_W-1:0]  cfg_wdata_i
);

  pld_pkg::dp_cmd_t cmd;
  pld_pkg::dp_sts_t sts;

  pld_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pld_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

[sv/pld_datapath.sv]
// Decode state, history memory and output register of the PalmDOC decoder.
module pld_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pld_pkg::in_item_t            in_item_i,
  input  logic                         cfg_we_i,
  input  logic [pld_pkg::CAP_W-1:0]    cfg_wdata_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output pld_pkg::out_item_t           out_item_o,
  input  pld_pkg::dp_cmd_t             cmd_i,
  output pld_pkg::dp_sts_t             sts_o
);

  logic [7:0] hist_mem [pld_pkg::WINDOW_DEPTH];

  logic [pld_pkg::WIN_AW-1:0]  wi_q;
  logic [pld_pkg::RW_W-1:0]    rw_q;
  logic [pld_pkg::CAP_W-1:0]   tw_q, cap_q;
  logic [pld_pkg::CNT_W-1:0]   raw_q, raw_d;
  logic                        pend_q, pend_d;
  logic [7:0]                  ph_q, ph_d;
  logic                        halt_q, halt_d;

  // per-item working registers
  logic [7:0]                  byte_q, byte2_q, rdata_q;
  logic [pld_pkg::CNT_W-1:0]   cnt_q;
  logic [pld_pkg::WIN_AW-1:0]  dist_q;
  logic                        end_q;

  logic                        out_valid_q;
  pld_pkg::out_item_t          out_q;

  logic [7:0]                  tok;
  logic [pld_pkg::AFTER_W-1:0] after;
  logic                        rec_end, is_raw;
  logic [pld_pkg::CNT_W-1:0]   len_c, addend;
  logic [pld_pkg::WIN_AW-1:0]  dist_c;
  logic [pld_pkg::CAP_W:0]     sum_c;
  logic                        over_c, at_cap;
  pld_pkg::act_e               act_c;
  logic [7:0]                  emit_byte;
  logic [pld_pkg::WIN_AW-1:0]  raddr;

  assign tok     = in_item_i.in_byte;
  assign after   = in_item_i.bytes_after;  // 12-bit field cannot exceed RECORD_MAX-1
  assign rec_end = (after == '0);
  assign is_raw  = (tok >= pld_pkg::TOK_RAW_LO) && (tok <= pld_pkg::TOK_RAW_HI);
  assign len_c   = {1'b0, tok[2:0]} + pld_pkg::LEN_BIAS;
  assign dist_c  = {ph_q[5:0], tok[7:3]};
  assign addend  = pend_q ? len_c : (is_raw ? tok[pld_pkg::CNT_W-1:0] : 4'd2);
  assign sum_c   = {1'b0, tw_q} + {{(pld_pkg::CAP_W+1-pld_pkg::CNT_W){1'b0}}, addend};
  assign over_c  = sum_c > {1'b0, cap_q};
  assign at_cap  = tw_q >= cap_q;

  always_comb begin
    act_c  = pld_pkg::ACT_NONE;
    raw_d  = raw_q;
    pend_d = pend_q;
    ph_d   = ph_q;
    halt_d = halt_q;
    if (!halt_q) begin
      priority if (raw_q != '0) begin
        raw_d = raw_q - 4'd1;
        act_c = pld_pkg::ACT_ONE;
      end else if (pend_q) begin
        pend_d = 1'b0;
        if (over_c) begin
          halt_d = 1'b1;
        end else if (dist_c != '0 && {1'b0, dist_c} <= rw_q) begin
          act_c = pld_pkg::ACT_COPY;
        end
      end else if (at_cap) begin
        halt_d = 1'b1;
      end else if (is_raw) begin
        if ({{(pld_pkg::AFTER_W-8){1'b0}}, tok} > after || over_c) begin
          halt_d = 1'b1;
        end else begin
          raw_d = tok[pld_pkg::CNT_W-1:0];
        end
      end else if (tok >= pld_pkg::TOK_SPACE_LO) begin
        if (over_c) halt_d = 1'b1;
        else act_c = pld_pkg::ACT_TWO;
      end else if (tok >= pld_pkg::TOK_PAIR_LO) begin
        if (rec_end) begin
          halt_d = 1'b1;
        end else begin
          pend_d = 1'b1;
          ph_d   = tok;
        end
      end else begin
        act_c = pld_pkg::ACT_ONE;
      end
    end
    if (rec_end) begin
      raw_d  = '0;
      pend_d = 1'b0;
      ph_d   = '0;
      halt_d = 1'b0;
    end
  end

  assign emit_byte = cmd_i.from_mem ? rdata_q : byte_q;
  assign raddr     = wi_q - dist_q;

  assign sts_o.act      = act_c;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = (cnt_q == 4'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wi_q        <= '0;
      rw_q        <= '0;
      tw_q        <= '0;
      cap_q       <= pld_pkg::CAP_RESET;
      raw_q       <= '0;
      pend_q      <= 1'b0;
      ph_q        <= '0;
      halt_q      <= 1'b0;
      cnt_q       <= '0;
      end_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        raw_q  <= raw_d;
        pend_q <= pend_d;
        ph_q   <= ph_d;
        halt_q <= halt_d;
        end_q  <= rec_end;
        unique case (act_c)
          pld_pkg::ACT_TWO:  cnt_q <= 4'd2;
          pld_pkg::ACT_COPY: cnt_q <= len_c;
          pld_pkg::ACT_ONE:  cnt_q <= 4'd1;
          default:           cnt_q <= '0;
        endcase
        // a token that yields nothing closes the record at once
        if (act_c == pld_pkg::ACT_NONE && rec_end) rw_q <= '0;
      end
      if (cmd_i.emit) begin
        wi_q  <= wi_q + 1'b1;
        tw_q  <= tw_q + 1'b1;
        cnt_q <= cnt_q - 4'd1;
        if (cnt_q == 4'd1 && end_q) begin
          rw_q <= '0;
        end else if (rw_q < pld_pkg::RW_W'(pld_pkg::DIST_LIMIT)) begin
          rw_q <= rw_q + 1'b1;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      byte_q  <= (act_c == pld_pkg::ACT_TWO) ? pld_pkg::SPACE_CHAR : tok;
      byte2_q <= tok ^ pld_pkg::XOR_MASK;
      dist_q  <= dist_c;
    end
    if (cmd_i.emit) begin
      byte_q            <= byte2_q;
      out_q.out_byte    <= emit_byte;
      out_q.last_of_run <= (cnt_q == 4'd1);
    end
  end

  // history: one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) hist_mem[wi_q] <= emit_byte;
    if (cmd_i.rd_issue) rdata_q <= hist_mem[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[sv/pld_ctrl.sv]
// Sequencing state machine of the PalmDOC decoder.
module pld_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  pld_pkg::dp_sts_t  sts_i,
  output pld_pkg::dp_cmd_t  cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EMIT = 4'b0010,
    S_RD   = 4'b0100,
    S_WR   = 4'b1000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          unique case (sts_i.act)
            pld_pkg::ACT_ONE,
            pld_pkg::ACT_TWO:  state_d = S_EMIT;
            pld_pkg::ACT_COPY: state_d = S_RD;
            default:           state_d = S_IDLE;
          endcase
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (sts_i.last) state_d = S_IDLE;
        end
      end
      S_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_WR;
      end
      S_WR: begin
        cmd_o.from_mem = 1'b1;
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = sts_i.last ? S_IDLE : S_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[sv/pld_checker.sv]
// Port-level checks for the PalmDOC decoder, bound to the top level.
module pld_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input pld_pkg::out_item_t out_item_o
);

  // a stalled output item holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_item_o))
    else $error("output item changed while stalled");

  // while an item's bytes are still coming, no new item is taken
  a_busy_mid_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last_of_run |-> !in_ready_o)
    else $error("ready while item output is incomplete");

  // returning to ready after emitting always follows the final byte of an item
  a_ready_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_ready_o) |-> out_valid_o && out_item_o.last_of_run)
    else $error("ready rose without a final byte");

endmodule

bind palmdoc_lz77_decompressor pld_checker u_pld_checker (.*);

[bench/pld_decode_checker.sv]
// Checker for the PalmDOC decoder: predicts decoded bytes and compares them with the output channel.
`timescale 1ns / 100ps

module pld_decode_checker (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_ready_i,
  input  pld_pkg::in_item_t         in_item_i,
  input  logic                      out_valid_i,
  input  logic                      out_ready_i,
  input  pld_pkg::out_item_t        out_item_i,
  input  logic                      cfg_we_i,
  input  logic [pld_pkg::CAP_W-1:0] cfg_wdata_i,
  output int unsigned               pending_o,
  output int unsigned               fail_count_o
);

  // decoder state as the block should hold it
  logic [7:0]                 hist_mem [pld_pkg::WINDOW_DEPTH];
  logic [pld_pkg::WIN_AW-1:0] wr_ptr;
  int unsigned                rec_count;   // bytes decoded in this record, saturates at DIST_LIMIT
  logic [pld_pkg::CAP_W-1:0]  total_cnt;
  int unsigned                raw_rem;
  logic                       pair_wait;
  logic [7:0]                 pair_hi;
  logic                       halt_rec;
  logic [pld_pkg::CAP_W-1:0]  cap_limit;

  pld_pkg::out_item_t step_q[$];        // bytes from the item being decoded
  pld_pkg::out_item_t decoded_due[$];   // bytes still owed by the block

  task automatic put_byte(input logic [7:0] b);
    pld_pkg::out_item_t ob;
    hist_mem[wr_ptr] = b;
    wr_ptr = wr_ptr + 1'b1;
    if (rec_count < pld_pkg::DIST_LIMIT) rec_count++;
    total_cnt = total_cnt + 1'b1;
    ob.out_byte    = b;
    ob.last_of_run = 1'b0;
    step_q = {step_q, ob};
  endtask

  task automatic decode_item(input pld_pkg::in_item_t it);
    logic [7:0]                 tok;
    int unsigned                after;
    int unsigned                tw;
    int unsigned                cap;
    int unsigned                len;
    int unsigned                back_dist;
    logic [pld_pkg::WIN_AW-1:0] rd_ptr;
    tok   = it.in_byte;
    after = it.bytes_after;
    tw    = total_cnt;
    cap   = cap_limit;
    step_q.delete();
    if (!halt_rec) begin
      if (raw_rem != 0) begin
        raw_rem--;
        put_byte(tok);
      end else if (pair_wait) begin
        len       = tok[2:0] + pld_pkg::LEN_BIAS;
        back_dist = {pair_hi[5:0], tok[7:3]};
        pair_wait = 1'b0;
        if (tw + len > cap) begin
          halt_rec = 1'b1;
        end else if (back_dist != 0 && back_dist <= rec_count) begin
          // copy may overlap its own output
          for (int i = 0; i < len; i++) begin
            rd_ptr = wr_ptr - pld_pkg::WIN_AW'(back_dist);
            put_byte(hist_mem[rd_ptr]);
          end
        end
      end else if (tw >= cap) begin
        halt_rec = 1'b1;
      end else if (tok >= pld_pkg::TOK_RAW_LO && tok <= pld_pkg::TOK_RAW_HI) begin
        if (tok > after || tw + tok > cap) halt_rec = 1'b1;
        else raw_rem = tok;
      end else if (tok >= pld_pkg::TOK_SPACE_LO) begin
        if (tw + 2 > cap) begin
          halt_rec = 1'b1;
        end else begin
          put_byte(pld_pkg::SPACE_CHAR);
          put_byte(tok ^ pld_pkg::XOR_MASK);
        end
      end else if (tok >= pld_pkg::TOK_PAIR_LO) begin
        if (after == 0) begin
          halt_rec = 1'b1;
        end else begin
          pair_wait = 1'b1;
          pair_hi   = tok;
        end
      end else begin
        put_byte(tok);
      end
    end
    if (after == 0) begin
      rec_count = 0;
      raw_rem   = 0;
      pair_wait = 1'b0;
      pair_hi   = '0;
      halt_rec  = 1'b0;
    end
    if (step_q.size() > 0) step_q[step_q.size()-1].last_of_run = 1'b1;
    decoded_due = {decoded_due, step_q};
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pld_pkg::out_item_t want;
    if (!rst_ni) begin
      wr_ptr       = '0;
      rec_count    = 0;
      total_cnt    = '0;
      raw_rem      = 0;
      pair_wait    = 1'b0;
      pair_hi      = '0;
      halt_rec     = 1'b0;
      cap_limit    = pld_pkg::CAP_RESET;
      fail_count_o = 0;
      decoded_due.delete();
    end else begin
      if (cfg_we_i) cap_limit = cfg_wdata_i;
      if (out_valid_i && out_ready_i) begin
        if (decoded_due.size() == 0) begin
          $error("unexpected output item: out_byte 0x%02h last_of_run %0b",
                 out_item_i.out_byte, out_item_i.last_of_run);
          fail_count_o++;
        end else begin
          want = decoded_due.pop_front();
          if (out_item_i.out_byte !== want.out_byte) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, out_item_i.out_byte);
            fail_count_o++;
          end
          if (out_item_i.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b", want.last_of_run,
                   out_item_i.last_of_run);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && in_ready_i) decode_item(in_item_i);
    end
    pending_o = decoded_due.size();
  end

endmodule

[bench/tb.sv]
// Testbench top for the PalmDOC decoder: clock, reset, stimulus, idling and the verdict.
`timescale 1ns / 100ps

module tb;

  typedef logic [7:0] byte_q_t[$];

  localparam int unsigned DRAIN_CYCLES   = 30;    // longest token is a back-reference of 10 bytes
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned PHASE_ITEMS    = 125;

  logic                      clk_i = 1'b0;
  logic                      rst_ni;
  logic                      in_valid;
  logic                      in_ready;
  pld_pkg::in_item_t         in_item;
  logic                      out_valid;
  logic                      out_ready;
  pld_pkg::out_item_t        out_item;
  logic                      cfg_we;
  logic [pld_pkg::CAP_W-1:0] cfg_wdata;

  int unsigned               pending;
  int unsigned               fail_count;
  int unsigned               tx_idle_pct = 0;
  int unsigned               rx_idle_pct = 0;
  int unsigned               items_sent = 0;
  int unsigned               idle_cycles = 0;
  logic [pld_pkg::CAP_W-1:0] delivered = '0;   // decoded bytes since reset
  logic                      hold_go = 1'b0;

  always #6 clk_i = ~clk_i;

  palmdoc_lz77_decompressor dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  pld_decode_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_item_i    (in_item),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_item_i   (out_item),
    .cfg_we_i     (cfg_we),
    .cfg_wdata_i  (cfg_wdata),
    .pending_o    (pending),
    .fail_count_o (fail_count)
  );

  always @(posedge clk_i) begin
    if (out_valid && out_ready) delivered <= delivered + 1'b1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("** palmdoc_lz77_decompressor: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // receiver: random stalls, plus one long hold-off so the block backs up
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_go && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic send_item(input logic [7:0] tok, input logic [pld_pkg::AFTER_W-1:0] after);
    @(negedge clk_i);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk_i);
    end
    in_item  <= '{in_byte: tok, bytes_after: after};
    in_valid <= 1'b1;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    items_sent++;
  endtask

  // noisy records carry arbitrary byte counts except on the final item
  task automatic send_record(input byte_q_t rec, input bit noisy);
    int unsigned after;
    for (int k = 0; k < rec.size(); k++) begin
      after = rec.size() - 1 - k;
      if (noisy && after != 0 && $urandom_range(1)) after = $urandom_range(pld_pkg::RECORD_MAX - 1);
      send_item(rec[k], pld_pkg::AFTER_W'(after));
    end
  endtask

  // wait out every owed byte, then let a token that yields nothing finish
  task automatic settle();
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_capacity(input logic [pld_pkg::CAP_W-1:0] value);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // well-formed token stream; back-references mostly stay inside decoded text
  task automatic build_text(output byte_q_t rec);
    int unsigned goal;
    int unsigned produced;
    int unsigned n;
    int unsigned span;
    int unsigned len;
    logic [10:0] back_dist;
    rec = {};
    goal = $urandom_range(1, 40);
    produced = 0;
    while (rec.size() < goal) begin
      case ($urandom_range(9))
        3: begin
          n = $urandom_range(pld_pkg::TOK_RAW_LO, pld_pkg::TOK_RAW_HI);
          rec = {rec, 8'(n)};
          repeat (n) rec = {rec, 8'($urandom_range(255))};
          produced += n;
        end
        4, 5: begin
          rec = {rec, 8'($urandom_range(pld_pkg::TOK_SPACE_LO, 8'hFF))};
          produced += 2;
        end
        6, 7, 8: begin
          if (produced == 0) begin
            rec = {rec, 8'($urandom_range(8'h09, 8'h7F))};
            produced++;
          end else begin
            span = (produced > pld_pkg::DIST_LIMIT - 1) ? pld_pkg::DIST_LIMIT - 1 : produced;
            if ($urandom_range(1)) back_dist = 11'($urandom_range(1, (span > 8) ? 8 : span));
            else back_dist = 11'($urandom_range(1, span));
            len = $urandom_range(3, 10);
            rec = {rec, pld_pkg::TOK_PAIR_LO | {2'b00, back_dist[10:5]}};
            rec = {rec, {back_dist[4:0], 3'(len - pld_pkg::LEN_BIAS)}};
            produced += len;
          end
        end
        9: begin
          // arbitrary pair: zero distance, out of record or valid
          rec = {rec, 8'($urandom_range(pld_pkg::TOK_PAIR_LO, pld_pkg::TOK_SPACE_LO - 1))};
          rec = {rec, 8'($urandom_range(255))};
        end
        default: begin
          if ($urandom_range(15) == 0) rec = {rec, 8'h00};
          else rec = {rec, 8'($urandom_range(8'h09, 8'h7F))};
          produced++;
        end
      endcase
    end
  endtask

  initial begin
    byte_q_t     rec;
    int unsigned target;
    int unsigned pick;
    int unsigned cut;
    rst_ni    = 1'b0;
    in_valid  = 1'b0;
    in_item   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero capacity: every token halts
    write_capacity('0);
    send_record({8'h41, pld_pkg::TOK_SPACE_LO}, 1'b0);
    settle();

    write_capacity(pld_pkg::CAP_RESET);
    // literals, runs, space pairs, near/overlapping/zero/too-far references
    send_record({8'h00, 8'h7F, 8'h09,
                 8'h04, 8'hFF, 8'h80, 8'h00, 8'h01,
                 pld_pkg::TOK_RAW_LO, 8'hC1,
                 pld_pkg::TOK_SPACE_LO, 8'hFF,
                 pld_pkg::TOK_PAIR_LO, 8'h08,
                 pld_pkg::TOK_PAIR_LO, 8'h17,
                 pld_pkg::TOK_PAIR_LO, 8'h00,
                 8'hBF, 8'hFF,
                 8'h41}, 1'b0);
    // raw run cut off by record end
    send_record({8'h05, 8'h42, 8'h43}, 1'b0);
    // reference head on the last byte of a record
    send_record({8'h90}, 1'b0);
    settle();

    for (int p = 0; p < 3; p++) begin
      case (p)
        0: begin
          tx_idle_pct = 32;
          rx_idle_pct = 50;
        end
        1: begin
          tx_idle_pct = 50;
          rx_idle_pct = 32;
          write_capacity(delivered + pld_pkg::CAP_W'($urandom_range(30, 120)));
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
          write_capacity(pld_pkg::CAP_RESET);
          hold_go = 1'b1;
        end
      endcase
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(99);
        if (pick >= 85) begin
          rec = {};
          repeat ($urandom_range(1, 12)) rec = {rec, 8'($urandom_range(255))};
        end else begin
          build_text(rec);
          if (pick >= 70) begin
            cut = $urandom_range(1, rec.size());
            while (rec.size() > cut) void'(rec.pop_back());
          end
        end
        send_record(rec, pick >= 85);
      end
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("** palmdoc_lz77_decompressor: PASSED **");
    end else begin
      $display("** palmdoc_lz77_decompressor: FAILED **");
    end
    $finish;
  end

endmodule
